/* design/assert_macros.svh */
// Assertion helpers used by the checker file tdq_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define TDQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tdq assertion failed");

// Check prop at every rising edge of clk, reset included.
`define TDQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tdq assertion failed");

`endif

/* design/tdq_pkg.sv */
`default_nettype none
package tdq_pkg;

    localparam int DIR_COUNT = 4;
    localparam int ADDR_W    = 5;

    // Direction bit positions
    localparam int BIT_LEFT  = 0;
    localparam int BIT_RIGHT = 1;
    localparam int BIT_UP    = 2;
    localparam int BIT_DOWN  = 3;

    // Pending move codes
    localparam logic [2:0] MOVE_NONE = 3'd0;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DEADZONE   = 3'd0;
    localparam logic [2:0] REG_SMALL_TILT = 3'd1;
    localparam logic [2:0] REG_LARGE_TILT = 3'd2;
    localparam logic [2:0] REG_INVERT_X   = 3'd3;
    localparam logic [2:0] REG_INVERT_Y   = 3'd4;
    localparam logic [2:0] REG_COOLDOWN   = 3'd5;
    localparam logic [2:0] REG_GEST_RESET = 3'd6;

    // Register reset values
    localparam logic [14:0] DEADZONE_RST   = 15'd1311;
    localparam logic [14:0] SMALL_TILT_RST = 15'd3277;
    localparam logic [14:0] LARGE_TILT_RST = 15'd7373;
    localparam logic [23:0] COOLDOWN_RST   = 24'd200000;
    localparam logic [23:0] GEST_RESET_RST = 24'd100000;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic        [31:0] timestamp_us;
    } sample_t;

    typedef struct packed {
        logic [3:0] held_mask;
        logic [3:0] pressed_mask;
        logic [3:0] released_mask;
        logic [2:0] pending_move;
        logic       in_deadzone_flag;
    } result_t;

    typedef struct packed {
        logic [14:0] deadzone_level;
        logic [14:0] small_tilt_level;
        logic [14:0] large_tilt_level;
        logic        invert_x_axis;
        logic        invert_y_axis;
        logic [23:0] cooldown_us;
        logic [23:0] gesture_reset_us;
    } cfg_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic                 consume;
        logic                 in_dz;
        logic [DIR_COUNT-1:0] toward;
        logic [DIR_COUNT-1:0] hold_tilt;
        logic [DIR_COUNT-1:0] move_tilt;
        logic [31:0]          now;
    } cls_t;

    function automatic logic [2:0] move_code(input logic [1:0] dir);
        return {1'b0, dir} + 3'd1;
    endfunction

endpackage
`default_nettype wire

/* design/tdq_cfg.sv */
`default_nettype none
module tdq_cfg
    import tdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone_level   <= DEADZONE_RST;
            cfg_reg.small_tilt_level <= SMALL_TILT_RST;
            cfg_reg.large_tilt_level <= LARGE_TILT_RST;
            cfg_reg.invert_x_axis    <= 1'b1;
            cfg_reg.invert_y_axis    <= 1'b0;
            cfg_reg.cooldown_us      <= COOLDOWN_RST;
            cfg_reg.gesture_reset_us <= GEST_RESET_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DEADZONE:   cfg_reg.deadzone_level   <= pwdata[14:0];
                REG_SMALL_TILT: cfg_reg.small_tilt_level <= pwdata[14:0];
                REG_LARGE_TILT: cfg_reg.large_tilt_level <= pwdata[14:0];
                REG_INVERT_X:   cfg_reg.invert_x_axis    <= pwdata[0];
                REG_INVERT_Y:   cfg_reg.invert_y_axis    <= pwdata[0];
                REG_COOLDOWN:   cfg_reg.cooldown_us      <= pwdata[23:0];
                REG_GEST_RESET: cfg_reg.gesture_reset_us <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEADZONE:   prdata = {17'd0, cfg_reg.deadzone_level};
            REG_SMALL_TILT: prdata = {17'd0, cfg_reg.small_tilt_level};
            REG_LARGE_TILT: prdata = {17'd0, cfg_reg.large_tilt_level};
            REG_INVERT_X:   prdata = {31'd0, cfg_reg.invert_x_axis};
            REG_INVERT_Y:   prdata = {31'd0, cfg_reg.invert_y_axis};
            REG_COOLDOWN:   prdata = {8'd0, cfg_reg.cooldown_us};
            REG_GEST_RESET: prdata = {8'd0, cfg_reg.gesture_reset_us};
            default:        prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* design/tdq_front.sv */
`default_nettype none
module tdq_front
    import tdq_pkg::*;
(
    input  wire sample_t sample,
    input  wire cfg_t    cfg,
    output cls_t         cls
);

    logic signed [16:0] x;
    logic signed [16:0] y;
    logic        [16:0] ax;
    logic        [16:0] ay;
    logic        [16:0] dz;
    logic        [16:0] lg;
    logic        [16:0] sm;
    logic               x_out;
    logic               y_out;
    logic               ax_large;
    logic               ay_large;
    logic               ax_small;
    logic               ay_small;

    always_comb
    begin
        // Negate at 17 bits so the most negative sample stays exact
        x  = cfg.invert_x_axis ? -17'(sample.accel_x) : 17'(sample.accel_x);
        y  = cfg.invert_y_axis ? -17'(sample.accel_y) : 17'(sample.accel_y);
        ax = x[16] ? 17'(-x) : 17'(x);
        ay = y[16] ? 17'(-y) : 17'(y);
        dz = {2'b00, cfg.deadzone_level};
        lg = {2'b00, cfg.large_tilt_level};
        sm = {2'b00, cfg.small_tilt_level};

        x_out    = ax > dz;
        y_out    = ay > dz;
        ax_large = ax >= lg;
        ay_large = ay >= lg;
        ax_small = !ax_large && (ax >= sm);
        ay_small = !ay_large && (ay >= sm);

        cls.consume           = sample.mode;
        cls.in_dz             = (ax < dz) && (ay < dz);
        cls.toward[BIT_LEFT]  = x_out && x[16];
        cls.toward[BIT_RIGHT] = x_out && !x[16];
        cls.toward[BIT_UP]    = y_out && !y[16];
        cls.toward[BIT_DOWN]  = y_out && y[16];
        cls.hold_tilt         = {ay_large, ay_large, ax_large, ax_large};
        cls.move_tilt         = {ay_small, ay_small, ax_small, ax_small};
        cls.now               = sample.timestamp_us;
    end

endmodule
`default_nettype wire

/* design/tdq_queue.sv */
`default_nettype none
module tdq_queue
    import tdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cls_t push_data,
    input  wire logic pop,
    output logic      not_empty,
    output logic      full,
    output cls_t      head
);

    cls_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_empty = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* design/tdq_back.sv */
`default_nettype none
module tdq_back
    import tdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic item_valid,
    input  wire cls_t item,
    output logic      item_pop,
    output logic      result_valid,
    input  wire logic result_stall,
    output result_t   result
);

    logic [DIR_COUNT-1:0] held_reg,      held_next;
    logic [DIR_COUNT-1:0] gesture_reg,   gesture_next;
    logic [31:0]          stamp_reg [DIR_COUNT];
    logic [31:0]          stamp_next [DIR_COUNT];
    logic [31:0]          dz_entry_reg,  dz_entry_next;
    logic                 dz_active_reg, dz_active_next;
    logic [2:0]           queued_reg,    queued_next;
    logic                 valid_reg;
    result_t              result_reg,    result_next;

    logic [DIR_COUNT-1:0] pressed;
    logic [DIR_COUNT-1:0] released;
    logic [DIR_COUNT-1:0] cool_ok;
    logic [31:0]          dz_span;

    assign item_pop     = item_valid && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int d = 0; d < DIR_COUNT; d++)
            cool_ok[d] = (item.now - stamp_reg[d]) >= {8'd0, cfg.cooldown_us};
        dz_span = dz_active_reg ? (item.now - dz_entry_reg) : 32'd0;
    end

    always_comb
    begin
        held_next      = held_reg;
        gesture_next   = gesture_reg;
        stamp_next     = stamp_reg;
        dz_entry_next  = dz_entry_reg;
        dz_active_next = dz_active_reg;
        queued_next    = queued_reg;
        pressed        = '0;
        released       = '0;

        if (item.consume)
        begin
            queued_next = MOVE_NONE;
        end
        else if (item.in_dz)
        begin
            if (!dz_active_reg)
            begin
                dz_active_next = 1'b1;
                dz_entry_next  = item.now;
            end
            if (dz_span >= {8'd0, cfg.gesture_reset_us})
                gesture_next = '0;
            released  = held_reg;
            held_next = '0;
        end
        else
        begin
            dz_active_next = 1'b0;
            // Left, right, up, down in turn; the first move queued wins
            for (int d = 0; d < DIR_COUNT; d++)
            begin
                if (item.toward[d])
                begin
                    if (item.hold_tilt[d])
                    begin
                        if (!held_reg[d])
                        begin
                            held_next[d] = 1'b1;
                            pressed[d]   = 1'b1;
                        end
                    end
                    else if (item.move_tilt[d] && !gesture_reg[d] &&
                             queued_next == MOVE_NONE && cool_ok[d])
                    begin
                        gesture_next[d] = 1'b1;
                        queued_next     = move_code(2'(d));
                        stamp_next[d]   = item.now;
                    end
                end
                else if (held_reg[d])
                begin
                    held_next[d] = 1'b0;
                    released[d]  = 1'b1;
                end
            end
        end

        result_next.held_mask        = held_next;
        result_next.pressed_mask     = pressed;
        result_next.released_mask    = released;
        result_next.pending_move     = queued_next;
        result_next.in_deadzone_flag = dz_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            gesture_reg   <= '0;
            for (int d = 0; d < DIR_COUNT; d++)
                stamp_reg[d] <= 32'd0;
            dz_entry_reg  <= 32'd0;
            dz_active_reg <= 1'b0;
            queued_reg    <= MOVE_NONE;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                held_reg      <= held_next;
                gesture_reg   <= gesture_next;
                stamp_reg     <= stamp_next;
                dz_entry_reg  <= dz_entry_next;
                dz_active_reg <= dz_active_next;
                queued_reg    <= queued_next;
                valid_reg     <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
            result_reg <= result_next;
    end

endmodule
`default_nettype wire

/* design/tilt_to_direction_qualifier_unit.sv */
// Tilt-to-direction qualifier. Each transfer on the sample channel is either
// an accelerometer sample (mode 0: Q2.14 x/y plus a microsecond timestamp) or
// a request to consume the queued single move (mode 1); every transfer yields
// exactly one transfer on the result channel with held, pressed and released
// direction masks (bit0 left, bit1 right, bit2 up, bit3 down), the pending
// move code and the deadzone flag. Throughput is one item per clock while the
// result is not stalled: the front classifies a sample combinationally and
// writes it into a two-entry queue, and the back applies one queued item per
// cycle to the direction state and loads the result register and result_valid.
// The back's state update is what sets the rate; when the result is stalled
// the queue absorbs two more items before sample_stall rises.
// Program the registers over the APB port (byte address 4 * index) only while
// no item is in flight.
`default_nettype none
module tilt_to_direction_qualifier_unit
    import tdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Sample channel
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire sample_t           sample,

    // Result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,

    // Register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t cfg;
    cls_t cls;
    cls_t q_head;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    logic q_full;

    // Hold off new samples only while both queue entries are taken
    assign sample_stall = q_full;
    assign q_push       = sample_valid && !q_full;

    tdq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: inversion, magnitude and threshold compares
    tdq_front u_front (
        .sample (sample),
        .cfg    (cfg),
        .cls    (cls)
    );

    // Decouple acceptance from the stateful back end
    tdq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (cls),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    // Back: held/gesture/cooldown state and the result register
    tdq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (q_not_empty),
        .item         (q_head),
        .item_pop     (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

/* design/tdq_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module tdq_checker
    import tdq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_stall,
    input wire sample_t           sample,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire result_t           result,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready
);

    // A stalled result holds
    `TDQ_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result))

    // Pressed directions are held, released ones are not
    `TDQ_ASSERT(a_mask_consistent, result_valid |-> ((result.pressed_mask & ~result.held_mask) == 4'd0 && (result.released_mask & result.held_mask) == 4'd0))

    // Inside the deadzone nothing is held
    `TDQ_ASSERT(a_dz_no_held, result_valid && result.in_deadzone_flag |-> result.held_mask == 4'd0)

    // At most one direction per axis is held
    `TDQ_ASSERT(a_axis_exclusive, result_valid |-> !(result.held_mask[0] && result.held_mask[1]) && !(result.held_mask[2] && result.held_mask[3]))

    // Move code is none or within left..down
    `TDQ_ASSERT(a_move_range, result_valid |-> result.pending_move <= 3'd4)

endmodule

bind tilt_to_direction_qualifier_unit tdq_checker u_tdq_checker (.*);
`default_nettype wire
